// ----- hdl/tmcw_pkg.sv -----
package tmcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HIGH  = 8'h80;
	localparam logic [COL_W:0]    TAB_STEP = 8'd8;
	localparam logic [COL_W:0]    TAB_MASK = ~8'd7;

	typedef enum logic [1:0] {
		REQ_PUT     = 2'd0,
		REQ_CLEAR   = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_COPY,
		ST_BLANK,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] hw;
		logic [CELL_W-1:0] rdata;
		logic              scrolled;
	} res_t;

	function automatic logic [ADDR_W-1:0] cell_loc(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		cell_loc = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

// ----- hdl/tmcw_ram.sv -----
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/tmcw_ctrl.sv -----
module tmcw_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [1:0]                     req_type,
	input  logic [tmcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tmcw_pkg::ADDR_W-1:0]    read_address,
	input  logic [tmcw_pkg::ATTR_W-1:0]    attr,
	input  logic [tmcw_pkg::CELL_W-1:0]    mem_rdata,
	output tmcw_pkg::mem_req_t             mem_req,
	output tmcw_pkg::res_t                 res,
	output logic                           busy
);
	import tmcw_pkg::*;

	state_t            state_q, state_n;
	logic [ADDR_W-1:0] cnt_q, cnt_n;
	logic [COL_W-1:0]  col_q, col_n;
	logic [ROW_W-1:0]  row_q, row_n;
	logic [ADDR_W-1:0] hw_q, hw_n;
	logic              pend_s1, pend_n;
	logic [ADDR_W-1:0] waddr_s1, waddr_n;

	req_t              req_q;
	logic [CHAR_W-1:0] char_q;
	logic [ADDR_W-1:0] addr_q;

	logic [COL_W:0]    col_t;
	logic [ROW_W:0]    row_t;
	logic              put_wr;
	logic              scroll;
	logic [CELL_W-1:0] blank;

	assign blank = {attr, CH_SPACE};
	assign busy  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			hw_q    <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			col_q   <= col_n;
			row_q   <= row_n;
			hw_q    <= hw_n;
			pend_s1 <= pend_n;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= waddr_n;
		if (state_q == ST_IDLE && start) begin
			req_q  <= req_t'(req_type);
			char_q <= char_code;
			addr_q <= read_address;
		end
	end

	// cursor move for put and advance, with wrap and scroll
	always_comb begin
		col_t  = {1'b0, col_q};
		row_t  = {1'b0, row_q};
		put_wr = 1'b0;
		if (req_q == REQ_ADVANCE) begin
			col_t = col_t + 1'b1;
		end else begin
			priority if (char_q == CH_BS) begin
				if (col_q != '0) begin
					col_t = col_t - 1'b1;
				end
			end else if (char_q == CH_TAB) begin
				col_t = (col_t + TAB_STEP) & TAB_MASK;
			end else if (char_q == CH_CR) begin
				col_t = '0;
			end else if (char_q == CH_LF) begin
				col_t = '0;
				row_t = row_t + 1'b1;
			end else if (char_q >= CH_SPACE && char_q < CH_HIGH) begin
				put_wr = 1'b1;
				col_t  = col_t + 1'b1;
			end else begin
				// drop other control bytes and high bytes
				put_wr = 1'b0;
			end
		end
		if (col_t >= (COL_W+1)'(COLUMNS)) begin
			col_t = '0;
			row_t = row_t + 1'b1;
		end
		scroll = (row_t >= (ROW_W+1)'(ROWS));
		if (scroll) begin
			row_t = (ROW_W+1)'(ROWS - 1);
		end
	end

	always_comb begin
		state_n       = state_q;
		cnt_n         = cnt_q;
		col_n         = col_q;
		row_n         = row_q;
		hw_n          = hw_q;
		pend_n        = 1'b0;
		waddr_n       = waddr_s1;
		mem_req.we    = 1'b0;
		mem_req.waddr = cnt_q;
		mem_req.wdata = blank;
		mem_req.raddr = addr_q;
		res.valid     = 1'b0;
		res.col       = col_q;
		res.row       = row_q;
		res.hw        = hw_q;
		res.rdata     = '0;
		res.scrolled  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (req_q)
					REQ_PUT, REQ_ADVANCE: begin
						col_n = col_t[COL_W-1:0];
						row_n = row_t[ROW_W-1:0];
						if (req_q == REQ_PUT) begin
							hw_n          = cell_loc(row_t[ROW_W-1:0], col_t[COL_W-1:0]);
							mem_req.we    = put_wr;
							mem_req.waddr = cell_loc(row_q, col_q);
							mem_req.wdata = {attr, char_q};
						end
						if (scroll) begin
							state_n = ST_COPY;
							cnt_n   = '0;
						end else begin
							state_n   = ST_IDLE;
							res.valid = 1'b1;
							res.col   = col_n;
							res.row   = row_n;
							res.hw    = hw_n;
						end
					end
					REQ_CLEAR: begin
						col_n   = '0;
						row_n   = '0;
						hw_n    = '0;
						cnt_n   = '0;
						state_n = ST_CLEAR;
					end
					REQ_READ: begin
						state_n = ST_READ;
					end
					default: state_n = ST_IDLE;
				endcase
			end
			ST_READ: begin
				state_n   = ST_IDLE;
				res.valid = 1'b1;
				if (addr_q < ADDR_W'(CELLS)) begin
					res.rdata = mem_rdata;
				end
			end
			ST_COPY: begin
				// read a row below, write it back in the next cycle
				mem_req.we    = pend_s1;
				mem_req.waddr = waddr_s1;
				mem_req.wdata = mem_rdata;
				mem_req.raddr = cnt_q + ADDR_W'(COLUMNS);
				if (cnt_q < ADDR_W'(CELLS - COLUMNS)) begin
					pend_n  = 1'b1;
					waddr_n = cnt_q;
					cnt_n   = cnt_q + 1'b1;
				end else begin
					state_n = ST_BLANK;
				end
			end
			ST_BLANK, ST_CLEAR: begin
				mem_req.we = 1'b1;
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					state_n      = ST_IDLE;
					res.valid    = 1'b1;
					res.scrolled = (state_q == ST_BLANK);
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/text_mode_console_writer.sv -----
// Text-mode console writer: an 80x25 screen of 16-bit cells (attribute in
// the high byte, character in the low byte), kept in one synchronous RAM
// with a registered read, plus a cursor.
// Request channel: a transfer takes place at a clock edge with start high
// and busy low; req_type, char_code and read_address are sampled there.
// Attribute register: written at any edge with attr_we high; write only
// while busy is low and no result is outstanding.
// Result channel: done pulses for one cycle with cursor_col, cursor_row,
// hw_cursor_location, read_data and scrolled; the receiver cannot stall,
// so every result is taken in that cycle.
// A put or advance that scrolls copies the rows up through the single
// RAM read port, then blanks the last row; clear writes one cell per cycle.
// busy falls in the done cycle, so the next request may follow at once.
// Reset homes the cursor and the hardware cursor location and sets the
// attribute to 0x1F; screen contents are not cleared and stay unknown
// until written by a put, scroll or clear.
module text_mode_console_writer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [tmcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tmcw_pkg::ADDR_W-1:0] read_address,
	input  logic                        attr_we,
	input  logic [tmcw_pkg::ATTR_W-1:0] attr_data,
	output logic                        done,
	output logic [tmcw_pkg::COL_W-1:0]  cursor_col,
	output logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tmcw_pkg::ADDR_W-1:0] hw_cursor_location,
	output logic [tmcw_pkg::CELL_W-1:0] read_data,
	output logic                        scrolled
);
	import tmcw_pkg::*;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1F;

	logic [ATTR_W-1:0] attr_q;
	logic              done_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] hw_q;
	logic [CELL_W-1:0] rdata_q;
	logic              scrolled_q;

	mem_req_t          mem_req;
	res_t              res;
	logic [CELL_W-1:0] mem_rdata;

	// attribute used for glyphs and blanks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
			done_q <= 1'b0;
		end else begin
			if (attr_we) begin
				attr_q <= attr_data;
			end
			done_q <= res.valid;
		end
	end

	// hold the result fields until the next result replaces them
	always_ff @(posedge clk) begin
		if (res.valid) begin
			col_q      <= res.col;
			row_q      <= res.row;
			hw_q       <= res.hw;
			rdata_q    <= res.rdata;
			scrolled_q <= res.scrolled;
		end
	end

	tmcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.char_code    (char_code),
		.read_address (read_address),
		.attr         (attr_q),
		.mem_rdata    (mem_rdata),
		.mem_req      (mem_req),
		.res          (res),
		.busy         (busy)
	);

	tmcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	assign done               = done_q;
	assign cursor_col         = col_q;
	assign cursor_row         = row_q;
	assign hw_cursor_location = hw_q;
	assign read_data          = rdata_q;
	assign scrolled           = scrolled_q;

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cursor_col < COL_W'(COLUMNS) && cursor_row < ROW_W'(ROWS)))
		else $error("cursor left the screen");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> (cursor_row == ROW_W'(ROWS - 1)))
		else $error("scroll did not leave the cursor on the last row");
`endif

endmodule

// ----- bench/text_mode_console_writer_test.sv -----
`timescale 1ns / 100ps

module text_mode_console_writer_test;

	import tmcw_pkg::*;

	// Generous ceiling: over a thousand requests that all scroll, each behind
	// the longest request gap, taken several times over.
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int PHASE_ITEMS = 220;
	localparam int PHASES      = 5;

	typedef struct {
		req_t              kind;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
	} console_request_t;

	typedef struct {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] hw;
		logic [CELL_W-1:0] rdata;
		logic              scrolled;
	} console_report_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [1:0]          req_type     = REQ_PUT;
	logic [CHAR_W-1:0]   char_code    = '0;
	logic [ADDR_W-1:0]   read_address = '0;
	logic                attr_we      = 1'b0;
	logic [ATTR_W-1:0]   attr_data    = '0;
	logic                busy;
	logic                done;
	logic [COL_W-1:0]    cursor_col;
	logic [ROW_W-1:0]    cursor_row;
	logic [ADDR_W-1:0]   hw_cursor_location;
	logic [CELL_W-1:0]   read_data;
	logic                scrolled;

	// Requests waiting for the driver, and reports the console still owes us.
	console_request_t queued_requests[$];
	console_report_t  pending_reports[$];

	int unsigned issued_count = 0;
	int unsigned taken_count  = 0;
	int unsigned failures     = 0;
	int unsigned cycle_count  = 0;

	// Shadow copy of the console: screen, cursor, hardware cursor, attribute.
	logic [CELL_W-1:0] screen_model [CELLS];
	int                col_model  = 0;
	int                row_model  = 0;
	logic [ADDR_W-1:0] hw_model   = '0;
	logic [ATTR_W-1:0] attr_model = 8'h1F;

	text_mode_console_writer i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.req_type           (req_type),
		.char_code          (char_code),
		.read_address       (read_address),
		.attr_we            (attr_we),
		.attr_data          (attr_data),
		.done               (done),
		.cursor_col         (cursor_col),
		.cursor_row         (cursor_row),
		.hw_cursor_location (hw_cursor_location),
		.read_data          (read_data),
		.scrolled           (scrolled)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Wrap the column past the right edge, then scroll once the cursor falls
	// off the bottom row: lift every row by one and blank the last row.
	function automatic logic wrap_and_scroll();
		if (col_model >= COLUMNS) begin
			col_model = 0;
			row_model++;
		end
		if (row_model < ROWS)
			return 1'b0;
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen_model[i] = screen_model[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen_model[i] = {attr_model, CH_SPACE};
		row_model = ROWS - 1;
		return 1'b1;
	endfunction

	// Apply one request to the shadow console and return the report it owes.
	function automatic console_report_t console_apply(input req_t kind,
			input logic [CHAR_W-1:0] ch, input logic [ADDR_W-1:0] addr);
		console_report_t rep;
		rep.rdata    = '0;
		rep.scrolled = 1'b0;
		case (kind)
			REQ_PUT: begin
				if (ch == CH_BS) begin
					// backspace stops at the left edge
					if (col_model != 0)
						col_model--;
				end else if (ch == CH_TAB) begin
					col_model = (col_model + 8) & ~7;
				end else if (ch == CH_CR) begin
					col_model = 0;
				end else if (ch == CH_LF) begin
					col_model = 0;
					row_model++;
				end else if (ch >= CH_SPACE && ch < CH_HIGH) begin
					screen_model[row_model * COLUMNS + col_model] = {attr_model, ch};
					col_model++;
				end
				// other control bytes and high bytes fall through untouched
				rep.scrolled = wrap_and_scroll();
				hw_model = ADDR_W'(row_model * COLUMNS + col_model);
			end
			REQ_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_model[i] = {attr_model, CH_SPACE};
				col_model = 0;
				row_model = 0;
				hw_model  = '0;
			end
			REQ_ADVANCE: begin
				// hardware cursor deliberately left where it was
				col_model++;
				rep.scrolled = wrap_and_scroll();
			end
			default: begin
				if (addr < CELLS)
					rep.rdata = screen_model[addr];
			end
		endcase
		rep.col = COL_W'(col_model);
		rep.row = ROW_W'(row_model);
		rep.hw  = hw_model;
		return rep;
	endfunction

	task automatic queue_request(input req_t kind, input logic [CHAR_W-1:0] ch,
			input logic [ADDR_W-1:0] addr);
		console_request_t rq;
		rq.kind = kind;
		rq.ch   = ch;
		rq.addr = addr;
		queued_requests.push_back(rq);
	endtask

	task automatic report_failure(input string msg);
		if (failures < 10)
			$display("%0t: %s", $time, msg);
		failures++;
	endtask

	// Hold until every request has gone in and every report has come back.
	task automatic wait_idle();
		while (queued_requests.size() != 0 || issued_count != taken_count ||
				pending_reports.size() != 0)
			@(negedge clk);
	endtask

	// Driver: present one request at a time on the falling edge, hold it
	// until the transfer, then idle for a random gap before the next one.
	// The counter and the queue are updated with blocking assignments so that
	// wait_idle, also woken on the falling edge, sees both or neither.
	int unsigned gap_left  = 0;
	int unsigned calm_left = 0;

	always @(negedge clk) begin
		console_request_t rq;
		int unsigned roll;
		if (arst_n) begin
			if (issued_count != taken_count) begin
				// request still waiting for busy to drop: hold everything
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (queued_requests.size() != 0) begin
				rq = queued_requests.pop_front();
				req_type     <= rq.kind;
				char_code    <= rq.ch;
				read_address <= rq.addr;
				start        <= 1'b1;
				issued_count++;
				roll = $urandom_range(0, 99);
				if (calm_left != 0) begin
					calm_left--;
					gap_left = 0;
				end else if (roll < 3) begin
					// a stretch of back-to-back requests
					calm_left = $urandom_range(20, 60);
					gap_left  = 0;
				end else if (roll < 55) begin
					gap_left = 0;
				end else if (roll < 85) begin
					gap_left = $urandom_range(1, 4);
				end else if (roll < 97) begin
					gap_left = $urandom_range(5, 40);
				end else begin
					gap_left = $urandom_range(100, 400);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: on the rising edge, check any report against the oldest one
	// outstanding, then predict the report for a request transferred now.
	always @(posedge clk) begin
		console_report_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_reports.size() == 0) begin
					report_failure("report with no request outstanding");
				end else begin
					want = pending_reports.pop_front();
					if (cursor_col !== want.col)
						report_failure($sformatf("cursor_col: expected %0d, got %0d",
							want.col, cursor_col));
					if (cursor_row !== want.row)
						report_failure($sformatf("cursor_row: expected %0d, got %0d",
							want.row, cursor_row));
					if (hw_cursor_location !== want.hw)
						report_failure($sformatf("hw_cursor_location: expected %0d, got %0d",
							want.hw, hw_cursor_location));
					if (read_data !== want.rdata)
						report_failure($sformatf("read_data: expected %h, got %h",
							want.rdata, read_data));
					if (scrolled !== want.scrolled)
						report_failure($sformatf("scrolled: expected %b, got %b",
							want.scrolled, scrolled));
				end
			end
			if (start && !busy) begin
				pending_reports.push_back(console_apply(req_t'(req_type), char_code,
					read_address));
				taken_count <= taken_count + 1;
			end
		end
	end

	// Watchdog: drop the run if the console stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[text_mode_console_writer] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
		logic [ATTR_W-1:0] attr_choice;
		req_t kind;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset attribute. Until the first clear only
		// cells written just before may be read back.
		queue_request(REQ_PUT, 8'h41, '0);
		queue_request(REQ_PUT, 8'h7F, '0);
		queue_request(REQ_PUT, CH_SPACE, '0);
		queue_request(REQ_READ, '0, 11'd0);
		queue_request(REQ_READ, '0, 11'd1);
		queue_request(REQ_READ, '0, 11'd2047);
		queue_request(REQ_PUT, CH_BS, '0);
		queue_request(REQ_CLEAR, '0, '0);
		// from here every cell holds a known word
		queue_request(REQ_READ, '0, 11'd2);
		queue_request(REQ_PUT, CH_BS, '0);
		// run tabs across the row until the last one wraps onto the next row
		repeat (10)
			queue_request(REQ_PUT, CH_TAB, '0);
		queue_request(REQ_PUT, 8'h1F, 11'd2047);
		queue_request(REQ_PUT, CH_HIGH, '0);
		queue_request(REQ_PUT, 8'hFF, '0);
		queue_request(REQ_PUT, CH_CR, '0);
		queue_request(REQ_PUT, CH_LF, '0);
		queue_request(REQ_ADVANCE, 8'hFF, 11'd1999);
		queue_request(REQ_READ, 8'hFF, 11'd1999);
		wait_idle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       attr_choice = 8'h00;
				1:       attr_choice = 8'hFF;
				PHASES - 1: attr_choice = 8'h1F;
				default: attr_choice = ATTR_W'($urandom_range(0, 255));
			endcase
			// console is idle here: write the attribute for this phase
			@(negedge clk);
			attr_we    <= 1'b1;
			attr_data  <= attr_choice;
			attr_model  = attr_choice;
			@(negedge clk);
			attr_we <= 1'b0;

			// Mostly lines of text with line ends, tabs and corrections, so the
			// cursor walks down to the bottom and the screen scrolls; the rest
			// is noise bytes, cursor advances, reads and the odd clear.
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 399);
				ch   = CHAR_W'($urandom_range(0, 255));
				addr = ADDR_W'($urandom_range(0, 2047));
				kind = REQ_PUT;
				if (pick < 220) begin
					ch = CHAR_W'($urandom_range(32, 127));
				end else if (pick < 270) begin
					ch = CH_LF;
				end else if (pick < 285) begin
					ch = CH_CR;
				end else if (pick < 305) begin
					ch = CH_TAB;
				end else if (pick < 320) begin
					ch = CH_BS;
				end else if (pick < 340) begin
					if ($urandom_range(0, 1))
						ch = CHAR_W'($urandom_range(0, 31));
					else
						ch = CHAR_W'($urandom_range(128, 255));
				end else if (pick < 360) begin
					kind = REQ_ADVANCE;
				end else if (pick < 399) begin
					kind = REQ_READ;
					if ($urandom_range(0, 9) != 0)
						addr = ADDR_W'($urandom_range(0, CELLS - 1));
					else
						addr = ADDR_W'($urandom_range(CELLS, 2047));
				end else begin
					kind = REQ_CLEAR;
				end
				queue_request(kind, ch, addr);
			end
			wait_idle();
		end

		// let any stray report show itself before the verdict
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("[text_mode_console_writer] OK");
		else
			$display("[text_mode_console_writer] ERROR");
		$finish;
	end

endmodule
